// ===== design/kfli_pkg.sv =====
// Shared constants, types and codes of the keyframe linear interpolator.
`default_nettype none

package kfli_pkg;

  // Key table size and the widths that follow from it
  localparam int unsigned MAX_KEYS = 64;
  localparam int unsigned KEY_AW   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CNT_W    = $clog2(MAX_KEYS + 1);

  // Field widths
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned DELTA_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned VAL_W   = 32;

  // Interpolation datapath: signed differences, product, quotient
  localparam int unsigned DIFF_W    = 33;
  localparam int unsigned PROD_W    = 2 * DIFF_W;
  localparam int unsigned DIV_STEPS = PROD_W / 2;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int unsigned QSAT_BIT  = 40;
  localparam int unsigned SUM_W     = QSAT_BIT + 2;
  localparam logic [PROD_W-1:0] Q_LIMIT = PROD_W'(1) << QSAT_BIT;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RESTART = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_RD_SEC,
    ST_DIFF,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  v;
  } key_entry_t;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [DIFF_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ===== design/kfli_key_ram.sv =====
// Key table memory: one write port, one read port with registered read data.
`default_nettype none

module kfli_key_ram (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [kfli_pkg::KEY_AW-1:0] waddr_i,
  input  kfli_pkg::key_entry_t        wdata_i,
  input  logic                        re_i,
  input  logic [kfli_pkg::KEY_AW-1:0] raddr_i,
  output kfli_pkg::key_entry_t        rdata_o
);
  import kfli_pkg::*;

  key_entry_t mem [MAX_KEYS];
  key_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/kfli_div.sv =====
// Unsigned restoring divider, two quotient bits per cycle.
`default_nettype none

module kfli_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  kfli_pkg::div_req_t          req_i,
  output logic                        done_o,
  output logic [kfli_pkg::PROD_W-1:0] quot_o
);
  import kfli_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIFF_W-1:0]    rem_q, rem_d;
  logic [PROD_W-1:0]    shf_q, shf_d;
  logic [DIFF_W-1:0]    dvs_q, dvs_d;

  logic [DIFF_W:0]   r1, r2, m1, m2;
  logic              ge1, ge2;
  logic [DIFF_W-1:0] rem1;

  always_comb begin
    // first bit of the pair
    r1   = {rem_q, shf_q[PROD_W-1]};
    ge1  = r1 >= {1'b0, dvs_q};
    m1   = ge1 ? (r1 - {1'b0, dvs_q}) : r1;
    rem1 = m1[DIFF_W-1:0];
    // second bit of the pair
    r2   = {rem1, shf_q[PROD_W-2]};
    ge2  = r2 >= {1'b0, dvs_q};
    m2   = ge2 ? (r2 - {1'b0, dvs_q}) : r2;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shf_d  = shf_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      shf_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = m2[DIFF_W-1:0];
      shf_d = {shf_q[PROD_W-3:0], ge1, ge2};
      cnt_d = cnt_q + DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = shf_q;

endmodule

`default_nettype wire

// ===== design/keyframe_linear_interpolator_core.sv =====
// Top level of the keyframe linear interpolator: sequencer, playback state, output register.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, action_i, delta_time_i, | into block
//           | key_time_i, key_value_i                         |
//   out     | out_valid_o, out_ready_i, value_o,              | out of block
//           | value_valid_o, finished_o, table_overflow_o     |
//
// Append, restart, status-only words and ticks that touch no key answer in the cycle
// after acceptance. A tick that reads only the current key answers after a table read,
// a decide step and the output load. A lerp passes through two table reads, a diff and
// a multiply step, the divider start, the steps of the 2-bit-per-cycle divider, its done
// flag and the output load; equal key times skip the divider.
// Reset clears playback state and the key count; the table itself is not cleared.
// A new word is taken only in idle while the output register is empty or drains.
`default_nettype none

module keyframe_linear_interpolator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [kfli_pkg::ACT_W-1:0]        action_i,
  input  logic [kfli_pkg::DELTA_W-1:0]      delta_time_i,
  input  logic [kfli_pkg::TIME_W-1:0]       key_time_i,
  input  logic signed [kfli_pkg::VAL_W-1:0] key_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [kfli_pkg::VAL_W-1:0] value_o,
  output logic                              value_valid_o,
  output logic                              finished_o,
  output logic                              table_overflow_o
);
  import kfli_pkg::*;

  // playback state
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  key_count_q, key_count_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [TIME_W-1:0] duration_q, duration_d;
  logic              done_q, done_d;
  logic              adv_q, adv_d;

  // lerp operands
  key_entry_t        prv_q, prv_d, nxt_q, nxt_d;
  logic [DIFF_W-1:0] mdt_q, mdt_d, mdv_q, mdv_d, mdk_q, mdk_d;
  logic              neg_q, neg_d, dkz_q, dkz_d;
  logic [VAL_W-1:0]  res_value_q, res_value_d;
  logic              res_valid_q, res_valid_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [VAL_W-1:0]  out_value_q, out_value_d;
  logic              out_vv_q, out_vv_d;
  logic              out_fin_q, out_fin_d;
  logic              out_ovf_q, out_ovf_d;
  logic              load_out;
  logic              out_free;
  logic              accept;

  // memory and divider hookup
  logic              ram_we, ram_re;
  logic [KEY_AW-1:0] ram_waddr, ram_raddr;
  key_entry_t        ram_wdata, ram_rdata;
  div_req_t          div_req;
  logic              div_done;
  logic [PROD_W-1:0] div_quot;

  // datapath helpers
  logic [TIME_W:0]          el_sum;
  logic [TIME_W-1:0]        el_new;
  logic [CNT_W-1:0]         idx_inc, idx_dec, idx_new;
  logic                     cur_adv;
  logic signed [DIFF_W-1:0] dt_s, dv_s, dk_s;
  logic [PROD_W-1:0]        q_sat;
  logic [SUM_W-1:0]         q_mag, vp_ext, sum;
  logic [VAL_W-1:0]         sum_clamped;
  logic                     sum_ovf;

  kfli_key_ram u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  kfli_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  // saturating elapsed time
  assign el_sum  = {1'b0, elapsed_q} + {{(TIME_W + 1 - DELTA_W){1'b0}}, delta_time_i};
  assign el_new  = el_sum[TIME_W] ? '1 : el_sum[TIME_W-1:0];
  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);

  // signed differences of the two bracketing keys
  assign dt_s = $signed({1'b0, elapsed_q}) - $signed({1'b0, prv_q.t});
  assign dv_s = $signed({nxt_q.v[VAL_W-1], nxt_q.v}) - $signed({prv_q.v[VAL_W-1], prv_q.v});
  assign dk_s = $signed({1'b0, nxt_q.t}) - $signed({1'b0, prv_q.t});

  // clamp quotient, apply sign, saturate to the value range
  assign q_sat  = (div_quot > Q_LIMIT) ? Q_LIMIT : div_quot;
  assign q_mag  = {1'b0, q_sat[QSAT_BIT:0]};
  assign vp_ext = {{(SUM_W - VAL_W){prv_q.v[VAL_W-1]}}, prv_q.v};
  assign sum    = neg_q ? (vp_ext - q_mag) : (vp_ext + q_mag);
  assign sum_ovf = !((&sum[SUM_W-1:VAL_W-1]) || !(|sum[SUM_W-1:VAL_W-1]));
  assign sum_clamped = !sum_ovf ? sum[VAL_W-1:0]
                     : (sum[SUM_W-1] ? {1'b1, {(VAL_W - 1){1'b0}}}
                                     : {1'b0, {(VAL_W - 1){1'b1}}});

  always_comb begin
    state_d     = state_q;
    key_count_d = key_count_q;
    idx_d       = idx_q;
    elapsed_d   = elapsed_q;
    duration_d  = duration_q;
    done_d      = done_q;
    adv_d       = adv_q;
    prv_d       = prv_q;
    nxt_d       = nxt_q;
    mdt_d       = mdt_q;
    mdv_d       = mdv_q;
    mdk_d       = mdk_q;
    neg_d       = neg_q;
    dkz_d       = dkz_q;
    res_value_d = res_value_q;
    res_valid_d = res_valid_q;
    out_value_d = out_value_q;
    out_vv_d    = out_vv_q;
    out_fin_d   = out_fin_q;
    out_ovf_d   = out_ovf_q;
    load_out    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = key_count_q[KEY_AW-1:0];
    ram_wdata   = '{t: key_time_i, v: key_value_i};
    ram_re      = 1'b0;
    ram_raddr   = idx_q[KEY_AW-1:0];
    div_req     = '{start: 1'b0, dividend: PROD_W'(mdt_q) * PROD_W'(mdv_q), divisor: mdk_q};
    cur_adv     = ram_rdata.t < elapsed_q;
    idx_new     = cur_adv ? idx_inc : idx_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // immediate status defaults; a tick that reads the table overrides
          load_out    = 1'b1;
          out_value_d = '0;
          out_vv_d    = 1'b0;
          out_fin_d   = done_q;
          out_ovf_d   = 1'b0;
          case (action_e'(action_i))
            ACT_APPEND: begin
              if (key_count_q == CNT_W'(MAX_KEYS)) begin
                out_ovf_d = 1'b1;
              end else begin
                ram_we      = 1'b1;
                key_count_d = key_count_q + CNT_W'(1);
                if (key_time_i > duration_q) begin
                  duration_d = key_time_i;
                end
              end
            end
            ACT_TICK: begin
              if (!done_q) begin
                elapsed_d = el_new;
                done_d    = el_new > duration_q;
                out_fin_d = done_d;
                if ((key_count_q != '0) && (idx_q < key_count_q)) begin
                  // fetch the current key; answer comes later
                  load_out = 1'b0;
                  ram_re   = 1'b1;
                  state_d  = ST_RD_CUR;
                end
              end
            end
            ACT_RESTART: begin
              elapsed_d = '0;
              idx_d     = '0;
              done_d    = 1'b0;
              out_fin_d = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RD_CUR: begin
        // advance by at most one key, then pick the bracketing pair
        idx_d = idx_new;
        adv_d = cur_adv;
        if (idx_new == key_count_q) begin
          res_value_d = '0;
          res_valid_d = 1'b0;
          state_d     = ST_OUT;
        end else if (idx_new == '0) begin
          res_valid_d = elapsed_q >= ram_rdata.t;
          res_value_d = (elapsed_q >= ram_rdata.t) ? ram_rdata.v : '0;
          state_d     = ST_OUT;
        end else begin
          ram_re = 1'b1;
          if (cur_adv) begin
            prv_d     = ram_rdata;
            ram_raddr = idx_new[KEY_AW-1:0];
          end else begin
            nxt_d     = ram_rdata;
            ram_raddr = idx_dec[KEY_AW-1:0];
          end
          state_d = ST_RD_SEC;
        end
      end
      ST_RD_SEC: begin
        if (adv_q) begin
          nxt_d = ram_rdata;
        end else begin
          prv_d = ram_rdata;
        end
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        // take magnitudes and the sign of the quotient
        mdt_d   = dt_s[DIFF_W-1] ? DIFF_W'(-dt_s) : DIFF_W'(dt_s);
        mdv_d   = dv_s[DIFF_W-1] ? DIFF_W'(-dv_s) : DIFF_W'(dv_s);
        mdk_d   = dk_s[DIFF_W-1] ? DIFF_W'(-dk_s) : DIFF_W'(dk_s);
        neg_d   = (dt_s[DIFF_W-1] ^ dv_s[DIFF_W-1]) ^ dk_s[DIFF_W-1];
        dkz_d   = dk_s == '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (dkz_q) begin
          // equal key times: hold the later key's value
          res_value_d = nxt_q.v;
          res_valid_d = 1'b1;
          state_d     = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_value_d = sum_clamped;
          res_valid_d = 1'b1;
          state_d     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_value_d = res_value_q;
          out_vv_d    = res_valid_q;
          out_fin_d   = done_q;
          out_ovf_d   = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_valid_d = load_out ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      key_count_q <= '0;
      idx_q       <= '0;
      elapsed_q   <= '0;
      duration_q  <= '0;
      done_q      <= 1'b0;
      adv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_count_q <= key_count_d;
      idx_q       <= idx_d;
      elapsed_q   <= elapsed_d;
      duration_q  <= duration_d;
      done_q      <= done_d;
      adv_q       <= adv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prv_q       <= prv_d;
    nxt_q       <= nxt_d;
    mdt_q       <= mdt_d;
    mdv_q       <= mdv_d;
    mdk_q       <= mdk_d;
    neg_q       <= neg_d;
    dkz_q       <= dkz_d;
    res_value_q <= res_value_d;
    res_valid_q <= res_valid_d;
    out_value_q <= out_value_d;
    out_vv_q    <= out_vv_d;
    out_fin_q   <= out_fin_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = out_value_q;
  assign value_valid_o    = out_vv_q;
  assign finished_o       = out_fin_q;
  assign table_overflow_o = out_ovf_q;

endmodule

`default_nettype wire

// ===== tb/tb_keyframe_linear_interpolator_core.sv =====
// Testbench of the keyframe linear interpolator core: queued word driver, result checker.
module tb_keyframe_linear_interpolator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import kfli_pkg::*;

  // Action code with no meaning to the block; it only reports status
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]        act;
    logic [DELTA_W-1:0]      dt;
    logic [TIME_W-1:0]       kt;
    logic signed [VAL_W-1:0] kv;
  } word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    vld;
    logic                    fin;
    logic                    ovf;
  } answer_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ACT_W-1:0]        action = '0;
  logic [DELTA_W-1:0]      delta_time = '0;
  logic [TIME_W-1:0]       key_time = '0;
  logic signed [VAL_W-1:0] key_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] value;
  logic                    value_valid;
  logic                    finished;
  logic                    table_overflow;

  keyframe_linear_interpolator_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .delta_time_i     (delta_time),
    .key_time_i       (key_time),
    .key_value_i      (key_value),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .value_o          (value),
    .value_valid_o    (value_valid),
    .finished_o       (finished),
    .table_overflow_o (table_overflow)
  );

  // Words waiting to be driven, and answers waiting to come back
  word_t   word_q[$];
  answer_t answer_q[$];

  int      n_bad = 0;
  int      n_queued = 0;
  bit      in_fire = 1'b0;  // set at the rising edge when the block took a word
  bit      calm = 1'b0;     // no idling on either side once set
  int      in_gap = 0;
  int      out_gap = 0;
  int      in_mode = 0;
  int      out_mode = 0;
  int      mode_left = 0;

  // Key table shape as the stimulus side sees it
  int unsigned gen_keys = 0;
  int unsigned gen_dur = 0;

  // Player state mirrored for prediction
  logic [TIME_W-1:0]       pl_t[MAX_KEYS];
  logic signed [VAL_W-1:0] pl_v[MAX_KEYS];
  int unsigned             pl_count = 0;
  int unsigned             pl_idx = 0;
  logic [TIME_W-1:0]       pl_el = '0;
  logic [TIME_W-1:0]       pl_dur = '0;
  logic                    pl_done = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Interpolate between key i-1 and key i at the current elapsed time.
  // Work on exact signed differences, truncate the quotient toward zero,
  // clamp the quotient at 2^40 and the sum to the int32 range.
  function automatic logic [VAL_W-1:0] lerp_at(int unsigned i);
    longint      vp, dt, dv, dk, sum;
    logic [63:0] mdt, mdv, mdk, q;
    logic        neg;
    vp  = pl_v[i-1];
    dt  = longint'({32'd0, pl_el}) - longint'({32'd0, pl_t[i-1]});
    dv  = longint'(pl_v[i]) - vp;
    dk  = longint'({32'd0, pl_t[i]}) - longint'({32'd0, pl_t[i-1]});
    if (dk == 0) return pl_v[i];  // equal key times: take the key as is
    neg = ((dt < 0) != (dv < 0)) != (dk < 0);
    mdt = (dt < 0) ? -dt : dt;
    mdv = (dv < 0) ? -dv : dv;
    mdk = (dk < 0) ? -dk : dk;
    q   = (mdt * mdv) / mdk;
    if (q > 64'h100_0000_0000) q = 64'h100_0000_0000;
    sum = neg ? vp - longint'(q) : vp + longint'(q);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // Advance the mirrored player by one word and return the answer it gives
  function automatic answer_t next_answer(word_t w);
    answer_t     a;
    logic [32:0] s;
    a = '0;
    case (w.act)
      ACT_APPEND: begin
        if (pl_count >= MAX_KEYS) begin
          a.ovf = 1'b1;  // full table: drop the key, keep the duration
        end else begin
          pl_t[pl_count] = w.kt;
          pl_v[pl_count] = w.kv;
          pl_count++;
          if (w.kt > pl_dur) pl_dur = w.kt;
        end
      end
      ACT_TICK: begin
        if (!pl_done) begin
          s     = {1'b0, pl_el} + w.dt;
          pl_el = s[32] ? '1 : s[31:0];  // hold elapsed at its maximum
          if (pl_count > 0 && pl_idx < pl_count) begin
            if (pl_t[pl_idx] < pl_el) pl_idx++;
            if (pl_idx < pl_count) begin
              if (pl_idx == 0) begin
                if (pl_el >= pl_t[0]) begin
                  a.value = pl_v[0];
                  a.vld   = 1'b1;
                end
              end else begin
                a.value = lerp_at(pl_idx);
                a.vld   = 1'b1;
              end
            end
          end
          if (pl_el > pl_dur) pl_done = 1'b1;
        end
      end
      ACT_RESTART: begin
        pl_el   = '0;
        pl_idx  = 0;
        pl_done = 1'b0;
      end
      default: ;
    endcase
    a.fin = pl_done;
    return a;
  endfunction

  // Decide whether a side starts an idle burst now
  function automatic bit take_break(int m);
    if (calm) return 1'b0;
    case (m)
      1:       return $urandom_range(0, 15) == 0;
      2:       return $urandom_range(0, 2) == 0;
      default: return 1'b0;
    endcase
  endfunction

  task automatic queue_word(input logic [ACT_W-1:0] a, input logic [DELTA_W-1:0] d,
                            input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] v);
    word_t w;
    w.act = a;
    w.dt  = d;
    w.kt  = t;
    w.kv  = v;
    word_q = {word_q, w};
    n_queued++;
  endtask

  // Queue one key append; mostly past the current end, sometimes repeated or out of order
  task automatic queue_key(input bit ordered);
    logic [TIME_W-1:0] t;
    logic [VAL_W-1:0]  v;
    case (ordered ? 7 : $urandom_range(0, 7))
      0:       t = gen_dur;
      1:       t = $urandom_range(0, gen_dur);
      default: t = gen_dur + $urandom_range(1, 3000);
    endcase
    v = $urandom;
    if ($urandom_range(0, 2) != 0) v = {{12{v[19]}}, v[19:0]};
    if (t > gen_dur) gen_dur = t;
    gen_keys++;
    queue_word(ACT_APPEND, DELTA_W'($urandom), t, v);
  endtask

  // Hold the sender until every word has been answered
  task automatic drain();
    while (word_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk);
  endtask

  // Driver: change inputs at the falling edge only
  always @(negedge clk) begin : drive
    word_t w;
    if (rst_n) begin
      if (mode_left == 0) begin
        in_mode   = $urandom_range(0, 2);
        out_mode  = $urandom_range(0, 2);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      // Input side: the slot frees when the word went in at the last rising edge
      if (!in_valid || in_fire) begin
        if (in_fire && take_break(in_mode)) in_gap = $urandom_range(1, 17);
        if (in_gap > 0 || word_q.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          w = word_q.pop_front();
          action     <= w.act;
          delta_time <= w.dt;
          key_time   <= w.kt;
          key_value  <= w.kv;
          in_valid   <= 1'b1;
        end
      end
      // Output side: stall in bursts
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (take_break(out_mode)) out_gap = $urandom_range(1, 17);
      end
    end
  end

  // Monitor: sample at the rising edge, predict on input, check on output
  always @(posedge clk) begin : watch
    word_t   cur;
    answer_t got;
    answer_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        cur.act = action;
        cur.dt  = delta_time;
        cur.kt  = key_time;
        cur.kv  = key_value;
        answer_q = {answer_q, next_answer(cur)};
      end
      if (out_valid && out_ready) begin
        got.value = value;
        got.vld   = value_valid;
        got.fin   = finished;
        got.ovf   = table_overflow;
        if (answer_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected result at %0t: value %h valid %b finished %b overflow %b",
                     $realtime, got.value, got.vld, got.fin, got.ovf);
        end else begin
          want = answer_q.pop_front();
          if (got.value !== want.value || got.vld !== want.vld ||
              got.fin !== want.fin || got.ovf !== want.ovf) begin
            n_bad++;
            if (n_bad <= 10)
              $display({"mismatch at %0t: value exp %h got %h, value_valid exp %b got %b, ",
                        "finished exp %b got %b, table_overflow exp %b got %b"},
                       $realtime, want.value, got.value, want.vld, got.vld,
                       want.fin, got.fin, want.ovf, got.ovf);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stim
    int unsigned dmax;
    int unsigned budget;
    int unsigned n;
    int          nnew;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Empty table: ticks drive nothing, a nonzero tick finishes at once
    queue_word(ACT_TICK, 16'd0, $urandom, $urandom);
    queue_word(ACT_TICK, 16'd5, $urandom, $urandom);
    queue_word(ACT_TICK, 16'hFFFF, $urandom, $urandom);  // finished: no change
    queue_word(ACT_UNUSED, DELTA_W'($urandom), $urandom, $urandom);
    queue_word(ACT_RESTART, DELTA_W'($urandom), $urandom, $urandom);
    // Extreme values, equal key times, keys out of order
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd100, 32'h7FFF_FFFF);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd200, 32'h8000_0000);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd200, 32'h0001_0000);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd50, 32'h1234_5678);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd51, 32'h7FFF_0000);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'd70000, 32'h0000_0000);
    gen_keys = 6;
    gen_dur  = 70000;
    queue_word(ACT_TICK, 16'd50, $urandom, $urandom);     // before the first key
    queue_word(ACT_TICK, 16'd50, $urandom, $urandom);     // on the first key
    queue_word(ACT_TICK, 16'd50, $urandom, $urandom);     // max to min lerp
    queue_word(ACT_TICK, 16'd50, $urandom, $urandom);
    queue_word(ACT_TICK, 16'd1, $urandom, $urandom);      // equal key times
    queue_word(ACT_TICK, 16'd1, $urandom, $urandom);      // key time goes backward
    queue_word(ACT_TICK, 16'hFFFF, $urandom, $urandom);   // extrapolate far, clamp
    queue_word(ACT_TICK, 16'd0, $urandom, $urandom);
    queue_word(ACT_TICK, 16'd5000, $urandom, $urandom);   // past the last key, finish
    queue_word(ACT_TICK, 16'd7, $urandom, $urandom);
    queue_word(ACT_RESTART, DELTA_W'($urandom), $urandom, $urandom);
    drain();

    // Random playback sessions; keep the last table slot for the closing run
    while (n_queued < 1150) begin
      nnew = $urandom_range(0, 3);
      for (int k = 0; k < nnew; k++)
        if (gen_keys < MAX_KEYS - 1) queue_key(1'b0);
      if ($urandom_range(0, 5) != 0)
        queue_word(ACT_RESTART, DELTA_W'($urandom), $urandom, $urandom);
      case ($urandom_range(0, 7))
        0:       dmax = 16;
        5, 6:    dmax = 8000;
        7:       dmax = 65535;
        default: dmax = $urandom_range(32, 1500);
      endcase
      budget = 0;
      n      = 0;
      while (budget <= gen_dur && n < 150) begin
        case ($urandom_range(0, 59))
          0:       queue_word(ACT_UNUSED, DELTA_W'($urandom), $urandom, $urandom);
          1:       queue_word(ACT_RESTART, DELTA_W'($urandom), $urandom, $urandom);
          2:       if (gen_keys < MAX_KEYS - 1) queue_key(1'b1);
          default: begin
            queue_word(ACT_TICK, DELTA_W'($urandom_range(0, dmax)), $urandom, $urandom);
            budget += dmax / 2;
          end
        endcase
        n++;
      end
      // A few more ticks so that finished playback is exercised too
      nnew = $urandom_range(0, 2);
      for (int k = 0; k < nnew; k++)
        queue_word(ACT_TICK, DELTA_W'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 9) == 0) drain();
    end

    // Closing run without idling: fill the table, end it at the largest time,
    // then keep ticking at the largest step
    drain();
    calm = 1'b1;
    while (gen_keys < MAX_KEYS - 1) queue_key(1'b1);
    queue_word(ACT_APPEND, DELTA_W'($urandom), 32'hFFFF_FFFF, $urandom);
    queue_word(ACT_APPEND, DELTA_W'($urandom), $urandom, $urandom);  // table full
    queue_word(ACT_APPEND, DELTA_W'($urandom), $urandom, $urandom);
    queue_word(ACT_RESTART, DELTA_W'($urandom), $urandom, $urandom);
    for (int k = 0; k < 30; k++) queue_word(ACT_TICK, 16'hFFFF, $urandom, $urandom);
    queue_word(ACT_TICK, 16'd0, $urandom, $urandom);
    queue_word(ACT_UNUSED, DELTA_W'($urandom), $urandom, $urandom);

    drain();
    repeat (60) @(posedge clk);
    if (n_bad == 0 && answer_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run
  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
